@@ rtl/tpi_pkg.sv @@
package tpi_pkg;

  localparam int MaxDegree = 5;
  localparam int NumCoeff  = MaxDegree + 1;
  localparam int FracBits  = 16;
  localparam int StepFrac  = 24;
  localparam int StepShift = 32 - StepFrac;
  localparam int QDepth    = 2;

  localparam int CoeffW = 32;
  localparam int XW     = 32;
  localparam int SumW   = 64;
  localparam int DegW   = 3;
  localparam int IdxW   = 3;

  localparam logic [CoeffW-1:0] Max32 = {1'b0, {(CoeffW-1){1'b1}}};
  localparam logic [CoeffW-1:0] Min32 = {1'b1, {(CoeffW-1){1'b0}}};
  localparam logic [SumW-1:0]   Max64 = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0]   Min64 = {1'b1, {(SumW-1){1'b0}}};

  localparam logic [31:0] StepReset = 32'd16777216;

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] REG_COEFF_0 = 3'd0;
  localparam logic [IdxW-1:0] REG_COEFF_1 = 3'd1;
  localparam logic [IdxW-1:0] REG_COEFF_2 = 3'd2;
  localparam logic [IdxW-1:0] REG_COEFF_3 = 3'd3;
  localparam logic [IdxW-1:0] REG_COEFF_4 = 3'd4;
  localparam logic [IdxW-1:0] REG_COEFF_5 = 3'd5;
  localparam logic [IdxW-1:0] REG_DEGREE  = 3'd6;
  localparam logic [IdxW-1:0] REG_STEP    = 3'd7;

  typedef enum logic [1:0] {
    KIND_INNER,
    KIND_FIRST,
    KIND_LAST,
    KIND_SINGLE
  } tpi_kind_t;

  typedef struct packed {
    logic [XW-1:0] x;
    tpi_kind_t     kind;
  } tpi_item_t;

  typedef struct packed {
    logic      valid;
    tpi_item_t item;
  } tpi_qhead_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } tpi_fstat_t;

  typedef struct packed {
    logic emitting;
    logic idle;
  } tpi_bstat_t;

  typedef struct packed {
    logic [NumCoeff-1:0][CoeffW-1:0] coeff;
    logic [DegW-1:0]                 degree;
    logic [31:0]                     step;
  } tpi_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ACCUM,
    ST_ABS,
    ST_SC_LO,
    ST_SC_HI,
    ST_FIN1,
    ST_FIN2,
    ST_EMIT
  } tpi_state_t;

  // Saturate a 64-bit signed value to 32 bits; bit 32 of the result flags saturation.
  function automatic logic [CoeffW:0] sat32(input logic [SumW-1:0] v);
    logic hi_same;
    hi_same = (v[SumW-1:CoeffW-1] == {(SumW-CoeffW+1){1'b0}}) ||
              (v[SumW-1:CoeffW-1] == {(SumW-CoeffW+1){1'b1}});
    if (hi_same) begin
      sat32 = {1'b0, v[CoeffW-1:0]};
    end else if (v[SumW-1]) begin
      sat32 = {1'b1, Min32};
    end else begin
      sat32 = {1'b1, Max32};
    end
  endfunction

endpackage

@@ rtl/trapezoid_polynomial_integrator.sv @@
// Channel | Direction | Ports                                | Payload
// in      | slave     | in_tvalid/in_tready/in_tdata/tuser/tlast | x_value, first, last
// out     | master    | out_tvalid/out_tready/out_tdata/tuser    | integral, overflow
// cfg     | slave     | cfg_valid/cfg_ready/cfg_index/cfg_data   | register writes
//
// A sample of degree d runs d Horner steps in the back part, each a multiply
// state (one 32x32 product) and an add state; a last sample then adds absolute
// value, scaling (two 32x32 partial products), final saturation and emit.
// Reset rst_n is synchronous: queue, sequencer, sum, flag and output go empty.
// A two-entry request queue takes input while the back part works, and the
// output register holds a result while the back part starts the next request.
module trapezoid_polynomial_integrator
  import tpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [XW-1:0]     in_tdata,   // [31:0] x_value
  input  logic              in_tuser,   // [0] first_sample
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [SumW-1:0]   out_tdata,  // [63:0] integral
  output logic              out_tuser,  // [0] overflow
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [NumCoeff-1:0][CoeffW-1:0] coeff_r;
  logic [DegW-1:0]                 degree_r;
  logic [31:0]                     step_r;
  logic                            cfg_we;

  tpi_cfg_t   cfg;
  tpi_qhead_t q_head;
  tpi_fstat_t fstat;
  tpi_bstat_t bstat;
  logic       pop;

  // The user must write configuration only while idle; the block does not enforce it and always accepts
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r  <= '0;
      degree_r <= '0;
      step_r   <= StepReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEFF_0: coeff_r[0] <= cfg_data;
        REG_COEFF_1: coeff_r[1] <= cfg_data;
        REG_COEFF_2: coeff_r[2] <= cfg_data;
        REG_COEFF_3: coeff_r[3] <= cfg_data;
        REG_COEFF_4: coeff_r[4] <= cfg_data;
        REG_COEFF_5: coeff_r[5] <= cfg_data;
        REG_DEGREE:  degree_r   <= cfg_data[DegW-1:0];
        REG_STEP:    step_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.coeff  = coeff_r;
  assign cfg.degree = degree_r;
  assign cfg.step   = step_r;

  // Front: accept and classify requests into the queue
  tpi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .pop       (pop),
    .q_head    (q_head),
    .fstat     (fstat)
  );

  // Back: evaluate, accumulate, scale and emit
  tpi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_head     (q_head),
    .pop        (pop),
    .bstat      (bstat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Never drain an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (fstat.count != 2'd0))
    else $error("pop from empty request queue");

  // A new result only comes from the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(bstat.emitting))
    else $error("result shown without emit step");

  // A pop only leaves the idle state
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !bstat.idle)
    else $error("sequencer stayed idle after pop");

  // Full queue holds off the input side
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (fstat.count == QDepth[1:0]) |-> (fstat.full && !in_tready))
    else $error("input accepted into full queue");

endmodule

@@ rtl/tpi_front.sv @@
module tpi_front
  import tpi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [XW-1:0]    in_tdata,
  input  logic             in_tuser,
  input  logic             in_tlast,
  input  logic             pop,
  output tpi_qhead_t       q_head,
  output tpi_fstat_t       fstat
);

  tpi_item_t  q_mem_r [QDepth];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  tpi_kind_t  kind;

  // Classify by the first and last tags
  always_comb begin
    unique case ({in_tlast, in_tuser})
      2'b00:   kind = KIND_INNER;
      2'b01:   kind = KIND_FIRST;
      2'b10:   kind = KIND_LAST;
      default: kind = KIND_SINGLE;
    endcase
  end

  assign in_tready = (count_r != QDepth[1:0]);
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{x: in_tdata, kind: kind};
    end
  end

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.item  = q_mem_r[rd_ptr_r];
  assign fstat.count  = count_r;
  assign fstat.full   = !in_tready;

endmodule

@@ rtl/tpi_back.sv @@
module tpi_back
  import tpi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tpi_cfg_t         cfg,
  input  tpi_qhead_t       q_head,
  output logic             pop,
  output tpi_bstat_t       bstat,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [SumW-1:0]  out_tdata,
  output logic             out_tuser
);

  tpi_state_t state_r, state_nxt;

  logic signed [XW-1:0]     x_r;
  tpi_kind_t                kind_r;
  logic signed [CoeffW-1:0] acc_r;
  logic [DegW-1:0]          d_r;
  logic                     eval_ov_r;
  logic signed [SumW-1:0]   prod_r;
  logic [SumW-1:0]          sum_r;
  logic                     ov_seen_r;
  logic                     neg_r;
  logic [SumW-1:0]          mag_r;
  logic [SumW-1:0]          plo_r;
  logic [SumW-1:0]          phi_r;
  logic [SumW-1:0]          r_r;
  logic                     hiov_r;
  logic [SumW-1:0]          res_r;
  logic                     resov_r;
  logic                     out_valid_r;
  logic [SumW-1:0]          out_data_r;
  logic                     out_ov_r;

  logic [DegW-1:0]   deg_eff;
  logic              slot_free;
  logic              load_out;

  // Horner step datapath
  logic [SumW-1:0]   shifted;
  logic [CoeffW:0]   p_sat;
  logic [CoeffW-1:0] c_lo;
  logic [CoeffW:0]   hsum;
  logic              hsum_ov;
  logic [CoeffW-1:0] acc_new;

  // Accumulate datapath
  logic [SumW-1:0]   y;
  logic [SumW-1:0]   base;
  logic              obase;
  logic [SumW:0]     asum;
  logic              add_ov;
  logic [SumW-1:0]   sum_new;

  // Final scaling
  logic              fin_ov;
  logic [SumW-1:0]   fin_res;

  assign deg_eff   = (cfg.degree > MaxDegree[DegW-1:0]) ? MaxDegree[DegW-1:0] : cfg.degree;
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          pop = 1'b1;
          if (q_head.item.kind == KIND_SINGLE) begin
            state_nxt = ST_EMIT;
          end else if (deg_eff == '0) begin
            state_nxt = ST_ACCUM;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL:   state_nxt = ST_ADD;
      ST_ADD:   state_nxt = (d_r == 3'd1) ? ST_ACCUM : ST_MUL;
      ST_ACCUM: state_nxt = (kind_r == KIND_LAST) ? ST_ABS : ST_IDLE;
      ST_ABS:   state_nxt = ST_SC_LO;
      ST_SC_LO: state_nxt = ST_SC_HI;
      ST_SC_HI: state_nxt = ST_FIN1;
      ST_FIN1:  state_nxt = ST_FIN2;
      ST_FIN2:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    shifted = SumW'(prod_r >>> FracBits);
    p_sat   = sat32(shifted);
    c_lo    = cfg.coeff[d_r - 3'd1];
    hsum    = {p_sat[CoeffW-1], p_sat[CoeffW-1:0]} + {c_lo[CoeffW-1], c_lo};
    hsum_ov = hsum[CoeffW] != hsum[CoeffW-1];
    if (hsum_ov) begin
      acc_new = hsum[CoeffW] ? Min32 : Max32;
    end else begin
      acc_new = hsum[CoeffW-1:0];
    end
  end

  always_comb begin
    y = {{(SumW-CoeffW){acc_r[CoeffW-1]}}, acc_r};
    if (kind_r != KIND_INNER) begin
      y = {y[SumW-1], y[SumW-1:1]};
    end
    base   = (kind_r == KIND_FIRST) ? '0 : sum_r;
    obase  = (kind_r == KIND_FIRST) ? 1'b0 : ov_seen_r;
    asum   = {base[SumW-1], base} + {y[SumW-1], y};
    add_ov = asum[SumW] != asum[SumW-1];
    if (add_ov) begin
      sum_new = asum[SumW] ? Min64 : Max64;
    end else begin
      sum_new = asum[SumW-1:0];
    end
  end

  always_comb begin
    if (hiov_r) begin
      fin_ov  = 1'b1;
      fin_res = neg_r ? Min64 : Max64;
    end else if (!neg_r) begin
      fin_ov  = r_r[SumW-1];
      fin_res = r_r[SumW-1] ? Max64 : r_r;
    end else begin
      // Magnitude of exactly 2^63 is the most negative value, no saturation
      fin_ov  = r_r[SumW-1] && (|r_r[SumW-2:0]);
      fin_res = fin_ov ? Min64 : (~r_r + 64'd1);
    end
  end

  // Running sum and flag carry across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      ov_seen_r <= 1'b0;
    end else if (pop && q_head.item.kind == KIND_SINGLE) begin
      sum_r     <= '0;
      ov_seen_r <= 1'b0;
    end else if (state_r == ST_ACCUM) begin
      sum_r     <= sum_new;
      ov_seen_r <= obase | eval_ov_r | add_ov;
    end else if (state_r == ST_FIN2) begin
      sum_r     <= '0;
      ov_seen_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          x_r       <= q_head.item.x;
          kind_r    <= q_head.item.kind;
          acc_r     <= cfg.coeff[deg_eff];
          d_r       <= deg_eff;
          eval_ov_r <= 1'b0;
          res_r     <= '0;
          resov_r   <= 1'b0;
        end
      end
      ST_MUL: prod_r <= SumW'(acc_r) * SumW'(x_r);
      ST_ADD: begin
        acc_r     <= acc_new;
        d_r       <= d_r - 3'd1;
        eval_ov_r <= eval_ov_r | p_sat[CoeffW] | hsum_ov;
      end
      ST_ABS: begin
        neg_r <= sum_r[SumW-1];
        mag_r <= sum_r[SumW-1] ? (~sum_r + 64'd1) : sum_r;
      end
      ST_SC_LO: plo_r <= {32'd0, mag_r[31:0]} * {32'd0, cfg.step};
      ST_SC_HI: phi_r <= {32'd0, mag_r[63:32]} * {32'd0, cfg.step};
      ST_FIN1: begin
        hiov_r <= (phi_r >> (63 - StepShift)) != '0;
        r_r    <= (phi_r << StepShift) + (plo_r >> StepFrac);
      end
      ST_FIN2: begin
        res_r   <= fin_res;
        resov_r <= ov_seen_r | fin_ov;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one result while the back part goes on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= res_r;
      out_ov_r   <= resov_r;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign out_tuser      = out_ov_r;
  assign bstat.emitting = (state_r == ST_EMIT);
  assign bstat.idle     = (state_r == ST_IDLE);

endmodule

@@ dv/tb_trapezoid_polynomial_integrator.sv @@
module tb_trapezoid_polynomial_integrator;
  import tpi_pkg::*;

  // Watchdog limit: cycles without any handshake on any channel. The longest
  // legal quiet stretch is the forced receiver hold plus the drain pause.
  localparam int WatchdogLimit = 5000;
  // The drain pause must cover the back part's worst case for each of up to three
  // requests that sit in the queue and sequencer.
  localparam int DrainCycles   = 100;
  localparam int NumSamples    = 1400;
  localparam int LongHold      = 400;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [XW-1:0] x;
    logic          is_first;
    logic          is_last;
  } sample_t;

  typedef struct {
    logic [SumW-1:0] integral;
    logic            ovf;
  } integral_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [XW-1:0]     in_tdata   = '0;   // [31:0] x_value
  logic              in_tuser   = 1'b0; // [0] first_sample
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [SumW-1:0]   out_tdata;         // [63:0] integral
  logic              out_tuser;         // [0] overflow
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index  = '0;
  logic [31:0]       cfg_data   = '0;

  trapezoid_polynomial_integrator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  sample_t     pending_samples[$];    // requests waiting for the driver
  integral_t   expected_integrals[$]; // predicted results, oldest first
  sample_t     cur_sample;            // request currently offered on in_*
  idle_mode_t  idle_mode = IDLE_NONE;
  int unsigned hold_token = 0;        // bump to start one long receiver hold
  int unsigned error_count = 0;
  int unsigned samples_planned = 0;
  int unsigned samples_accepted = 0;
  int unsigned integrals_seen = 0;
  int unsigned flagged_seen = 0;
  int unsigned settings_used = 0;

  // Integrator image: coefficients, degree, step, running sum and flag
  logic signed [CoeffW-1:0] mdl_coeff [NumCoeff] = '{default: '0};
  logic [DegW-1:0]          mdl_degree = '0;
  logic [31:0]              mdl_step   = StepReset;
  logic signed [SumW-1:0]   mdl_sum    = '0;
  logic                     mdl_ovf    = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Clamp to signed 32 bits; bit 32 flags a clamp.
  function automatic logic [CoeffW:0] clamp32(input logic signed [SumW-1:0] v);
    if (v > 64'sd2147483647) return {1'b1, Max32};
    if (v < -64'sd2147483648) return {1'b1, Min32};
    return {1'b0, v[CoeffW-1:0]};
  endfunction

  // Horner evaluation at x; bit 32 flags any clamp along the way.
  function automatic logic [CoeffW:0] horner_eval(input logic signed [XW-1:0] x);
    int unsigned              d;
    logic signed [CoeffW-1:0] acc;
    logic signed [SumW-1:0]   a64;
    logic signed [SumW-1:0]   x64;
    logic signed [SumW-1:0]   c64;
    logic [CoeffW:0]          c;
    logic                     ov;
    // degrees six and seven behave as the highest supported degree
    d   = (mdl_degree > MaxDegree) ? MaxDegree : mdl_degree;
    acc = mdl_coeff[d];
    ov  = 1'b0;
    x64 = x;
    while (d > 0) begin
      d--;
      a64 = acc;
      c   = clamp32((a64 * x64) >>> FracBits);
      ov  = ov | c[CoeffW];
      a64 = $signed(c[CoeffW-1:0]);
      c64 = mdl_coeff[d];
      c   = clamp32(a64 + c64);
      ov  = ov | c[CoeffW];
      acc = c[CoeffW-1:0];
    end
    return {ov, acc};
  endfunction

  // Sum times Q8.24 step, magnitude truncated; bit 64 flags saturation.
  function automatic logic [SumW:0] scale_by_step_width(input logic signed [SumW-1:0] s);
    logic            neg;
    logic [SumW-1:0] mag;
    logic [SumW-1:0] p_lo;
    logic [SumW-1:0] p_hi;
    logic [SumW-1:0] r;
    neg  = s[SumW-1];
    mag  = neg ? -s : s;
    p_lo = {32'b0, mag[31:0]} * {32'b0, mdl_step};
    p_hi = {32'b0, mag[63:32]} * {32'b0, mdl_step};
    if ((p_hi >> (63 - StepShift)) != 0) return {1'b1, neg ? Min64 : Max64};
    r = (p_hi << StepShift) + (p_lo >> StepFrac);
    if (!neg) begin
      if (r > Max64) return {1'b1, Max64};
      return {1'b0, r};
    end
    // Min64 read unsigned is 2^63, the one negative magnitude that still fits
    if (r > Min64) return {1'b1, Min64};
    return {1'b0, -r};
  endfunction

  // Advance the integrator image by one accepted request.
  function automatic void predict_sample(input sample_t smp);
    logic [CoeffW:0]        ev;
    logic [SumW:0]          sc;
    logic signed [SumW-1:0] y;
    logic signed [SumW-1:0] total;
    logic                   ov;
    integral_t              res;
    if (smp.is_first) begin
      mdl_sum = '0;
      mdl_ovf = 1'b0;
    end
    // a single-sample sequence integrates to zero
    if (smp.is_first && smp.is_last) begin
      res.integral = '0;
      res.ovf      = 1'b0;
      expected_integrals.push_back(res);
      return;
    end
    ev = horner_eval(smp.x);
    y  = $signed(ev[CoeffW-1:0]);
    ov = ev[CoeffW];
    // end samples carry half weight, floored
    if (smp.is_first || smp.is_last) y = y >>> 1;
    total = mdl_sum + y;
    if (mdl_sum[SumW-1] == y[SumW-1] && total[SumW-1] != y[SumW-1]) begin
      ov    = 1'b1;
      total = y[SumW-1] ? Min64 : Max64;
    end
    mdl_sum = total;
    if (ov) mdl_ovf = 1'b1;
    if (!smp.is_last) return;
    sc = scale_by_step_width(mdl_sum);
    res.integral = sc[SumW-1:0];
    res.ovf      = mdl_ovf | sc[SumW];
    expected_integrals.push_back(res);
    mdl_sum = '0;
    mdl_ovf = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_sample(input logic [XW-1:0] x, input logic f, input logic l);
    sample_t smp;
    smp.x        = x;
    smp.is_first = f;
    smp.is_last  = l;
    pending_samples.push_back(smp);
    samples_planned++;
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(9))
      0:       return Max32;
      1:       return Min32;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(524288)) - 32'd262144;  // within +-4.0
    endcase
  endfunction

  function automatic logic [XW-1:0] rand_x();
    case ($urandom_range(11))
      0:       return Max32;
      1:       return Min32;
      2:       return '0;
      3, 4:    return $urandom;
      default: return 32'($urandom_range(1048576)) - 32'd524288; // within +-8.0
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1;
      3:       return StepReset;
      4, 5:    return $urandom;
      default: return 32'($urandom_range(67108864, 1));          // up to 4.0
    endcase
  endfunction

  // Queue one sequence (or some noise); returns the number of requests added.
  function automatic int push_sequence(input int max_inner);
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 10) begin
      add_sample(rand_x(), 1'b1, 1'b1);
      return 1;
    end
    if (pick < 20) begin
      // noise: stray flags, interior runs, a last without a first
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++)
        add_sample(rand_x(), 1'($urandom_range(1)), 1'($urandom_range(1)));
      return n;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(max_inner);
    add_sample(rand_x(), 1'b1, 1'b0);
    for (int i = 0; i < n; i++) add_sample(rand_x(), 1'b0, 1'b0);
    add_sample(rand_x(), 1'b0, 1'b1);
    return n + 2;
  endfunction

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Write one register and mirror it; leaves cfg_valid high for back-to-back writes.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEGREE: mdl_degree = data[DegW-1:0];
      REG_STEP:   mdl_step   = data;
      default:    mdl_coeff[idx] = data;
    endcase
  endtask

  task automatic end_config();
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Hold the sender until every request went out and every integral came back,
  // then give samples that produce no result time to leave the back part.
  task automatic drain();
    wait (pending_samples.size() == 0 && !in_tvalid && expected_integrals.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [SumW-1:0] got,
                                 input logic [SumW-1:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued requests, predict on each accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_sample(cur_sample);
        samples_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 &&
            !roll(idle_mode == IDLE_SEND ? 73 : idle_mode == IDLE_BOTH ? 26 : 0)) begin
          cur_sample = pending_samples.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_sample.x;
          in_tuser  <= cur_sample.is_first;
          in_tlast  <= cur_sample.is_last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold per bump of hold_token
  // ---------------------------------------------------------------------------
  int unsigned hold_token_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_token != hold_token_seen) begin
        hold_token_seen = hold_token;
        hold_left       = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !roll(idle_mode == IDLE_RECV ? 73 : idle_mode == IDLE_BOTH ? 26 : 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  integral_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      integrals_seen++;
      if (expected_integrals.size() == 0) begin
        report_mismatch("unexpected integral", out_tdata, '0);
      end else begin
        want_res = expected_integrals.pop_front();
        if (want_res.ovf) flagged_seen++;
        if (out_tdata !== want_res.integral)
          report_mismatch("integral", out_tdata, want_res.integral);
        if (out_tuser !== want_res.ovf)
          report_mismatch("overflow", 64'(out_tuser), 64'(want_res.ovf));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no channel moves for too long
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no handshake for %0d cycles, %0d integrals outstanding",
               quiet_cycles, expected_integrals.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed checks, then random phases
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int in_phase;
    int phase_len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: single sample, then a last with nothing accumulated
    add_sample(32'h0003_0000, 1'b1, 1'b1);
    add_sample(32'h0001_0000, 1'b0, 1'b1);
    drain();

    // Quadratic 1 + 2x - 0.5x^2; higher coefficients must be ignored
    write_reg(REG_COEFF_0, 32'h0001_0000);
    write_reg(REG_COEFF_1, 32'h0002_0000);
    write_reg(REG_COEFF_2, 32'hFFFF_8000);
    write_reg(REG_COEFF_3, 32'h0000_4000);
    write_reg(REG_COEFF_4, Max32);
    write_reg(REG_COEFF_5, Min32);
    write_reg(REG_DEGREE,  32'd2);
    write_reg(REG_STEP,    StepReset);
    end_config();
    add_sample(32'h0000_0000, 1'b1, 1'b0);
    add_sample(32'h0001_0000, 1'b0, 1'b0);
    add_sample(32'h0002_0000, 1'b0, 1'b1);
    add_sample(Max32, 1'b1, 1'b0);
    add_sample(Min32, 1'b0, 1'b1);
    add_sample(32'h0003_0000, 1'b1, 1'b1);
    drain();

    // Full degree, every coefficient at the top: evaluation clamps
    for (int i = 0; i < NumCoeff; i++) write_reg(IdxW'(i), Max32);
    write_reg(REG_DEGREE, 32'd5);
    end_config();
    add_sample(Max32, 1'b1, 1'b0);
    add_sample(Min32, 1'b0, 1'b0);
    add_sample(32'h0001_0000, 1'b0, 1'b1);
    drain();

    // Degree above the maximum, coefficients at the bottom, widest step
    for (int i = 0; i < NumCoeff; i++) write_reg(IdxW'(i), Min32);
    write_reg(REG_DEGREE, 32'd7);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    end_config();
    add_sample(32'h0001_0000, 1'b1, 1'b0);
    add_sample(32'hFFFF_0000, 1'b0, 1'b0);
    add_sample(32'h0000_8000, 1'b0, 1'b1);
    // interior then last, no first: sum restarts from the cleared state
    add_sample(32'h0002_0000, 1'b0, 1'b0);
    add_sample(32'h0001_0000, 1'b0, 1'b1);
    drain();

    // Zero step gives zero whatever the sum
    write_reg(REG_COEFF_0, 32'h0001_0000);
    write_reg(REG_COEFF_1, 32'hFFFF_0000);
    write_reg(REG_DEGREE,  32'd1);
    write_reg(REG_STEP,    32'd0);
    end_config();
    add_sample(32'h0005_0000, 1'b1, 1'b0);
    add_sample(32'h0001_0000, 1'b0, 1'b1);
    drain();

    // Constant only, smallest step: truncation toward zero
    write_reg(REG_COEFF_0, 32'hFFFE_8000);
    write_reg(REG_DEGREE,  32'd0);
    write_reg(REG_STEP,    32'd1);
    end_config();
    add_sample(32'h1234_5678, 1'b1, 1'b0);
    add_sample(32'h8765_4321, 1'b0, 1'b1);
    drain();

    // Random phases: new settings, rotate idle mode, sender waits at each end
    phase = 0;
    while (samples_planned < NumSamples) begin
      for (int i = 0; i < NumCoeff; i++)
        if (roll(75)) write_reg(IdxW'(i), rand_coeff());
      write_reg(REG_DEGREE,
                roll(80) ? 32'($urandom_range(MaxDegree)) : 32'($urandom_range(7, 6)));
      if (roll(75)) write_reg(REG_STEP, rand_step());
      end_config();

      in_phase = 0;
      if (phase == 3) begin
        // starve the output: short sequences back up queue and output register
        idle_mode = IDLE_NONE;
        hold_token <= hold_token + 1;
        while (in_phase < 60) in_phase += push_sequence(1);
      end else begin
        idle_mode = idle_mode_t'(phase % 4);
        phase_len = $urandom_range(140, 60);
        while (in_phase < phase_len) in_phase += push_sequence(6);
      end
      drain();
      phase++;
    end

    $display("Covered %0d samples and %0d integrals (%0d with overflow) under %0d settings,",
             samples_accepted, integrals_seen, flagged_seen, settings_used);
    $display("with degrees up to seven, steps from zero to full scale and all idle mixes.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
